// ===== rtl/pf_pkg.sv =====
// package for the prime factorizer: microcode word, step addresses and program rom
package pf_pkg;

  localparam int unsigned MaxResults = 30;
  localparam int unsigned CntW       = 5;
  localparam int unsigned PcW        = 4;

  typedef logic [PcW-1:0]  pc_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_GO,
    OP_EMIT_D,
    OP_EMIT_REM,
    OP_EMIT_NONE,
    OP_NEXT_D
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_START,
    C_SMALL,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_R_NZ,
    C_CAP
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_word_t;

  localparam pc_t StepIdle     = 4'd0;
  localparam pc_t StepSmall    = 4'd1;
  localparam pc_t StepDivGo    = 4'd2;
  localparam pc_t StepDivWait  = 4'd3;
  localparam pc_t StepTest     = 4'd4;
  localparam pc_t StepHit      = 4'd5;
  localparam pc_t StepEmitD    = 4'd6;
  localparam pc_t StepLoop     = 4'd7;
  localparam pc_t StepExit     = 4'd8;
  localparam pc_t StepEmitNone = 4'd9;
  localparam pc_t StepNextD    = 4'd10;

  localparam cnt_t CapCount = cnt_t'(MaxResults - 1);

  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, cond: C_ALWAYS, target: StepIdle};
    case (pc)
      StepIdle:     cw = '{op: OP_LOAD,      cond: C_NOT_START, target: StepIdle};
      StepSmall:    cw = '{op: OP_NOP,       cond: C_SMALL,     target: StepEmitNone};
      StepDivGo:    cw = '{op: OP_DIV_GO,    cond: C_NEXT,      target: StepIdle};
      StepDivWait:  cw = '{op: OP_NOP,       cond: C_DIV_BUSY,  target: StepDivWait};
      StepTest:     cw = '{op: OP_NOP,       cond: C_D_GT_Q,    target: StepExit};
      StepHit:      cw = '{op: OP_NOP,       cond: C_R_NZ,      target: StepNextD};
      StepEmitD:    cw = '{op: OP_EMIT_D,    cond: C_CAP,       target: StepIdle};
      StepLoop:     cw = '{op: OP_NOP,       cond: C_ALWAYS,    target: StepDivGo};
      StepExit:     cw = '{op: OP_EMIT_REM,  cond: C_ALWAYS,    target: StepIdle};
      StepEmitNone: cw = '{op: OP_EMIT_NONE, cond: C_ALWAYS,    target: StepIdle};
      StepNextD:    cw = '{op: OP_NEXT_D,    cond: C_ALWAYS,    target: StepDivGo};
      default:      cw = '{op: OP_NOP,       cond: C_ALWAYS,    target: StepIdle};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/pf_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
module pf_divider #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W:0]    acc_shift;
  logic [W:0]    diff;

  assign acc_shift = {acc_q, quo_q[W-1]};
  assign diff      = acc_shift - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    if (go_i) begin
      cnt_d = CW'(W);
      acc_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      if (!diff[W]) begin
        acc_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        acc_d = acc_shift[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = acc_q;

endmodule

// ===== rtl/prime_factorizer_core.sv =====
// prime factorizer top level: microcoded trial division sequencer and datapath
//
// channel  direction  handshake                  payload
// input    in         start high, busy low       value_i
// result   out        valid_o, one cycle strobe  factor_o first_of_prime_o no_factors_o last_o
//
// each trial division runs on the bit-serial divider, and an item takes at most
// about sqrt(value) trials, worst case a large prime
// an input below 2 goes from the small-value step straight to the no-factor step
// busy stays high from acceptance until the last word goes out
// reset clears the step counter, the divider count and the strobe
// results are never stalled; one word leaves per strobe
module prime_factorizer_core #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] factor_o,
  output logic                  first_of_prime_o,
  output logic                  no_factors_o,
  output logic                  last_o
);

  localparam int unsigned W = VALUE_BITS;

  pf_pkg::pc_t        pc_q, pc_d;
  pf_pkg::ctrl_word_t cw;
  logic               take;

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dv_q, dv_d;
  logic          first_q, first_d;
  pf_pkg::cnt_t  cnt_q, cnt_d;

  logic          valid_q, valid_d;
  logic [W-1:0]  factor_q, factor_d;
  logic          fop_q, fop_d;
  logic          nof_q, nof_d;
  logic          last_q, last_d;

  logic          div_go;
  logic          div_busy;
  logic [W-1:0]  quo;
  logic [W-1:0]  rmd;
  logic          at_cap;

  pf_divider #(.W(W)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (div_go),
    .dividend_i  (rem_q),
    .divisor_i   (dv_q),
    .busy_o      (div_busy),
    .quotient_o  (quo),
    .remainder_o (rmd)
  );

  assign cw     = pf_pkg::ucode(pc_q);
  assign at_cap = (cnt_q == pf_pkg::CapCount);
  assign busy   = (pc_q != pf_pkg::StepIdle);

  // branch condition and step counter
  always_comb begin
    case (cw.cond)
      pf_pkg::C_NEXT:      take = 1'b0;
      pf_pkg::C_ALWAYS:    take = 1'b1;
      pf_pkg::C_NOT_START: take = !start;
      pf_pkg::C_SMALL:     take = (rem_q[W-1:1] == '0);
      pf_pkg::C_DIV_BUSY:  take = div_busy;
      pf_pkg::C_D_GT_Q:    take = (dv_q > quo);
      pf_pkg::C_R_NZ:      take = (rmd != '0);
      pf_pkg::C_CAP:       take = at_cap;
      default:             take = 1'b1;
    endcase
    pc_d = take ? cw.target : pc_q + pf_pkg::pc_t'(1);
  end

  // datapath operations
  always_comb begin
    rem_d    = rem_q;
    dv_d     = dv_q;
    first_d  = first_q;
    cnt_d    = cnt_q;
    div_go   = 1'b0;
    valid_d  = 1'b0;
    factor_d = factor_q;
    fop_d    = fop_q;
    nof_d    = nof_q;
    last_d   = last_q;
    case (cw.op)
      pf_pkg::OP_LOAD: begin
        if (start) begin
          rem_d   = value_i;
          dv_d    = W'(2);
          first_d = 1'b1;
          cnt_d   = '0;
        end
      end
      pf_pkg::OP_DIV_GO: begin
        div_go = 1'b1;
      end
      pf_pkg::OP_EMIT_D: begin
        valid_d  = 1'b1;
        factor_d = dv_q;
        fop_d    = first_q;
        nof_d    = 1'b0;
        last_d   = at_cap;
        rem_d    = quo;
        first_d  = 1'b0;
        cnt_d    = cnt_q + pf_pkg::cnt_t'(1);
      end
      pf_pkg::OP_EMIT_REM: begin
        // remainder equal to the current divisor repeats that prime
        valid_d  = 1'b1;
        factor_d = rem_q;
        fop_d    = first_q || (rem_q != dv_q);
        nof_d    = 1'b0;
        last_d   = 1'b1;
      end
      pf_pkg::OP_EMIT_NONE: begin
        valid_d  = 1'b1;
        factor_d = '0;
        fop_d    = 1'b0;
        nof_d    = 1'b1;
        last_d   = 1'b1;
      end
      pf_pkg::OP_NEXT_D: begin
        dv_d    = dv_q + W'(1);
        first_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= pf_pkg::StepIdle;
      valid_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    dv_q     <= dv_d;
    first_q  <= first_d;
    cnt_q    <= cnt_d;
    factor_q <= factor_d;
    fop_q    <= fop_d;
    nof_q    <= nof_d;
    last_q   <= last_d;
  end

  assign valid_o          = valid_q;
  assign factor_o         = factor_q;
  assign first_of_prime_o = fop_q;
  assign no_factors_o     = nof_q;
  assign last_o           = last_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_more_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy)
    else $error("non-final word while sequencer idle");

  a_none_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && no_factors_o) |-> (last_o && factor_o == '0 && !first_of_prime_o))
    else $error("bad no-factor word");

  a_factor_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !no_factors_o) |-> (factor_o[W-1:1] != '0))
    else $error("factor below two");

  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (pc_q == pf_pkg::StepDivWait))
    else $error("divider running outside wait step");

endmodule
